// ----- hdl/lsn_pkg.sv -----
// Package for the spiking network engine: sizes, command codes, the item type
// and the saturation helper. No dependencies.
package lsn_pkg;

    localparam int NEURON_COUNT   = 32;
    localparam int SYNAPSES       = 8;
    localparam int OUTPUT_NEURONS = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int SLOT_TOTAL     = NEURON_COUNT * SYNAPSES;
    localparam int OUT_BASE       = NEURON_COUNT - OUTPUT_NEURONS;
    localparam int IN_DATA_W      = 152;
    localparam logic [7:0]  REFRAC_RESET = 8'd10;
    localparam logic [23:0] SCALE_RESET  = 24'd65536;

    localparam logic [1:0] CMD_SYN   = 2'd0;
    localparam logic [1:0] CMD_NEUR  = 2'd1;
    localparam logic [1:0] CMD_SPIKE = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic CFG_REFRAC = 1'b0;
    localparam logic CFG_SCALE  = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  neuron;
        logic [2:0]  slot;
        logic [4:0]  source;
        logic        link_valid;
        logic [31:0] weight;
        logic [30:0] threshold;
        logic [30:0] rest_level;
        logic [15:0] leak_gain;
        logic [15:0] decay;
        logic        active;
        logic [7:0]  spike_count;
    } t_item;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/lsn_front.sv -----
// Front end: accepts command transactions, unpacks them and holds them in a
// two-entry queue for the engine. Depends on lsn_pkg.
module lsn_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lsn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,
    output logic                            o_valid,
    output lsn_pkg::t_item                  o_item,
    input  logic                            i_pop
);
    lsn_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    lsn_pkg::t_item w_in;
    logic           w_push, w_pop;

    always_comb begin
        w_in.cmd         = s_axis_tuser;
        w_in.neuron      = s_axis_tdata[4:0];
        w_in.slot        = s_axis_tdata[7:5];
        w_in.source      = s_axis_tdata[12:8];
        w_in.link_valid  = s_axis_tdata[13];
        w_in.weight      = s_axis_tdata[45:14];
        w_in.threshold   = s_axis_tdata[76:46];
        w_in.rest_level  = s_axis_tdata[107:77];
        w_in.leak_gain   = s_axis_tdata[123:108];
        w_in.decay       = s_axis_tdata[139:124];
        w_in.active      = s_axis_tdata[140];
        w_in.spike_count = s_axis_tdata[148:141];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_valid       = (r_cnt != 2'd0);
    assign w_pop         = i_pop && o_valid;
    assign o_item        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ----- hdl/lsn_engine.sv -----
// Back end: executes queued commands against the synapse and neuron stores
// and drives the result register. Depends on lsn_pkg.
module lsn_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [23:0]     i_cfg_data,
    input  logic            i_valid,
    input  lsn_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tuser,
    output logic            m_axis_tlast
);
    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_SP_RD  = 15'h0002,
        S_SP_WR  = 15'h0004,
        S_NEXT   = 15'h0008,
        S_RD     = 15'h0010,
        S_MUL1   = 15'h0020,
        S_DEC    = 15'h0040,
        S_MUL2   = 15'h0080,
        S_ACC    = 15'h0100,
        S_REF    = 15'h0200,
        S_LEAK1  = 15'h0400,
        S_LEAK2  = 15'h0800,
        S_FIRE   = 15'h1000,
        S_EMIT   = 15'h2000,
        S_END    = 15'h4000
    } t_state;

    t_state r_state;

    logic [7:0]  r_refrac_ticks;
    logic [23:0] r_spike_scale;

    // Synapse stores, one row per neuron.
    logic signed [31:0] r_cur_mem [lsn_pkg::SLOT_TOTAL];
    logic signed [31:0] r_wgt_mem [lsn_pkg::SLOT_TOTAL];
    logic [4:0]         r_src_mem [lsn_pkg::SLOT_TOTAL];
    logic [lsn_pkg::SLOT_TOTAL-1:0] r_syn_valid;
    logic [lsn_pkg::SLOT_TOTAL-1:0] r_cur_ok;
    logic signed [31:0] r_cur_q, r_wgt_q;
    logic [4:0]         r_src_q;

    // Neuron stores.
    logic signed [31:0] r_memb   [lsn_pkg::NEURON_COUNT];
    logic [7:0]         r_refrac [lsn_pkg::NEURON_COUNT];
    logic [30:0]        r_thr    [lsn_pkg::NEURON_COUNT];
    logic [30:0]        r_rest   [lsn_pkg::NEURON_COUNT];
    logic [15:0]        r_leak   [lsn_pkg::NEURON_COUNT];
    logic [15:0]        r_decay  [lsn_pkg::NEURON_COUNT];
    logic [lsn_pkg::NEURON_COUNT-1:0] r_active;

    logic [7:0]         r_k;
    logic [2:0]         r_j;
    logic [4:0]         r_i;
    logic [4:0]         r_from;
    logic [31:0]        r_add;
    logic               r_ret;
    logic signed [51:0] r_sum;
    logic signed [48:0] r_p1;
    logic signed [63:0] r_p2;
    logic signed [51:0] r_p3;
    logic signed [31:0] r_newcur;
    logic signed [34:0] r_drive;
    logic               r_fire;
    logic               r_pend_v;
    logic [2:0]         r_pend_idx;
    logic [3:0]         r_nres;
    logic               r_ovalid, r_ofired, r_olast;
    logic [2:0]         r_oidx;

    logic               w_cur_we;
    logic signed [31:0] w_cur_wd;
    logic               w_syn_we;
    logic [7:0]         w_syn_k;
    logic signed [31:0] w_cur;
    logic               w_ofree;
    logic               w_oset;
    logic [7:0]         w_rl;
    logic signed [31:0] w_s32;
    logic signed [35:0] w_dv;
    logic signed [31:0] w_v;
    logic               w_out_neuron;

    assign w_cur        = r_cur_ok[r_k] ? r_cur_q : 32'sd0;
    assign w_ofree      = !r_ovalid || m_axis_tready;
    assign w_syn_k      = {i_item.neuron, i_item.slot};
    assign w_syn_we     = (r_state == S_IDLE) && i_valid && (i_item.cmd == lsn_pkg::CMD_SYN);
    assign w_rl         = (r_refrac[r_i] != 8'd0) ? r_refrac[r_i] - 8'd1 : 8'd0;
    assign w_s32        = lsn_pkg::sat32(64'(r_sum));
    assign w_dv         = 36'(r_p3 >>> 16);
    assign w_v          = lsn_pkg::sat32(64'(r_memb[r_i]) + 64'(w_dv));
    assign w_out_neuron = (r_i >= 5'(lsn_pkg::OUT_BASE));

    // The result register is loaded when a held firing is released or a tick ends.
    assign w_oset = ((r_state == S_EMIT) && r_fire && w_out_neuron
                     && r_nres < 4'(lsn_pkg::MAX_RESULTS) && r_pend_v && w_ofree)
                    || ((r_state == S_END) && w_ofree);

    always_comb begin
        w_cur_we = 1'b0;
        w_cur_wd = lsn_pkg::sat32(64'(r_p1 >>> 16));
        if (r_state == S_DEC) begin
            w_cur_we = 1'b1;
        end else if (r_state == S_SP_WR && r_syn_valid[r_k] && r_src_q == r_from) begin
            w_cur_we = 1'b1;
            w_cur_wd = lsn_pkg::sat32(64'(w_cur) + 64'(r_add));
        end
    end

    assign o_pop         = (r_state == S_IDLE) && i_valid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_oidx};
    assign m_axis_tuser  = r_ofired;
    assign m_axis_tlast  = r_olast;

    // Synapse memories: one write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (w_cur_we) r_cur_mem[r_k] <= w_cur_wd;
        if (w_syn_we) begin
            r_wgt_mem[w_syn_k] <= i_item.weight;
            r_src_mem[w_syn_k] <= i_item.source;
        end
        r_cur_q <= r_cur_mem[r_k];
        r_wgt_q <= r_wgt_mem[r_k];
        r_src_q <= r_src_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_refrac_ticks <= lsn_pkg::REFRAC_RESET;
            r_spike_scale  <= lsn_pkg::SCALE_RESET;
            r_syn_valid    <= '0;
            r_cur_ok       <= '0;
            r_active       <= '0;
            r_ovalid       <= 1'b0;
            r_pend_v       <= 1'b0;
            for (int n = 0; n < lsn_pkg::NEURON_COUNT; n++) begin
                r_memb[n]   <= 32'sd0;
                r_refrac[n] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lsn_pkg::CFG_REFRAC) r_refrac_ticks <= i_cfg_data[7:0];
                else                                  r_spike_scale  <= i_cfg_data;
            end
            if (w_oset) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (w_cur_we) r_cur_ok[r_k] <= 1'b1;
            if (w_syn_we) r_syn_valid[w_syn_k] <= i_item.link_valid;

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_item.cmd)
                            lsn_pkg::CMD_NEUR: begin
                                r_thr[i_item.neuron]    <= i_item.threshold;
                                r_rest[i_item.neuron]   <= i_item.rest_level;
                                r_leak[i_item.neuron]   <= i_item.leak_gain;
                                r_decay[i_item.neuron]  <= i_item.decay;
                                r_active[i_item.neuron] <= i_item.active;
                            end
                            lsn_pkg::CMD_SPIKE: begin
                                r_from  <= i_item.neuron;
                                r_add   <= 32'(r_spike_scale) * 32'(i_item.spike_count);
                                r_k     <= 8'd0;
                                r_ret   <= 1'b0;
                                r_state <= S_SP_RD;
                            end
                            lsn_pkg::CMD_TICK: begin
                                r_i      <= 5'd0;
                                r_nres   <= 4'd0;
                                r_pend_v <= 1'b0;
                                r_state  <= S_NEXT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SP_RD: r_state <= S_SP_WR;
                S_SP_WR: begin
                    r_k <= r_k + 8'd1;
                    if (r_k == 8'(lsn_pkg::SLOT_TOTAL - 1)) begin
                        if (r_ret) begin
                            if (r_i == 5'(lsn_pkg::NEURON_COUNT - 1)) r_state <= S_END;
                            else begin
                                r_i     <= r_i + 5'd1;
                                r_state <= S_NEXT;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_SP_RD;
                    end
                end
                S_NEXT: begin
                    if (r_active[r_i]) begin
                        r_j     <= 3'd0;
                        r_k     <= {r_i, 3'd0};
                        r_sum   <= '0;
                        r_state <= S_RD;
                    end else if (r_i == 5'(lsn_pkg::NEURON_COUNT - 1)) begin
                        r_state <= S_END;
                    end else begin
                        r_i <= r_i + 5'd1;
                    end
                end
                S_RD: r_state <= S_MUL1;
                S_MUL1: begin
                    r_p1    <= w_cur * $signed({1'b0, r_decay[r_i]});
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_newcur <= w_cur_wd;
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= r_wgt_q * r_newcur;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_syn_valid[r_k]) r_sum <= r_sum + 52'(r_p2 >>> 16);
                    r_k <= r_k + 8'd1;
                    r_j <= r_j + 3'd1;
                    r_state <= (r_j == 3'(lsn_pkg::SYNAPSES - 1)) ? S_REF : S_RD;
                end
                S_REF: begin
                    r_refrac[r_i] <= w_rl;
                    r_drive <= 35'($signed({1'b0, r_rest[r_i]})) - 35'(r_memb[r_i])
                               + 35'(w_s32);
                    r_state <= (w_rl == 8'd0) ? S_LEAK1 : S_FIRE;
                end
                S_LEAK1: begin
                    r_p3    <= 52'(r_drive) * 52'($signed({1'b0, r_leak[r_i]}));
                    r_state <= S_LEAK2;
                end
                S_LEAK2: begin
                    r_memb[r_i] <= w_v[31] ? 32'sd0 : w_v;
                    r_state     <= S_FIRE;
                end
                S_FIRE: begin
                    r_fire <= (r_memb[r_i] >= $signed({1'b0, r_thr[r_i]}));
                    if (r_memb[r_i] >= $signed({1'b0, r_thr[r_i]})) begin
                        r_memb[r_i]   <= 32'sd0;
                        r_refrac[r_i] <= r_refrac_ticks;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // A firing is held back until the next one shows whether it is last.
                    if (r_fire && w_out_neuron && r_nres < 4'(lsn_pkg::MAX_RESULTS)
                        && r_pend_v && !w_ofree) begin
                        r_state <= S_EMIT;
                    end else begin
                        if (r_fire && w_out_neuron && r_nres < 4'(lsn_pkg::MAX_RESULTS)) begin
                            if (r_pend_v) begin
                                r_ofired <= 1'b1;
                                r_oidx   <= r_pend_idx;
                                r_olast  <= 1'b0;
                            end
                            r_pend_v   <= 1'b1;
                            r_pend_idx <= 3'(r_i - 5'(lsn_pkg::OUT_BASE));
                            r_nres     <= r_nres + 4'd1;
                        end
                        if (r_fire) begin
                            r_from  <= r_i;
                            r_add   <= 32'(r_spike_scale);
                            r_k     <= 8'd0;
                            r_ret   <= 1'b1;
                            r_state <= S_SP_RD;
                        end else if (r_i == 5'(lsn_pkg::NEURON_COUNT - 1)) begin
                            r_state <= S_END;
                        end else begin
                            r_i     <= r_i + 5'd1;
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_END: begin
                    if (w_ofree) begin
                        r_ofired <= r_pend_v;
                        r_oidx   <= r_pend_v ? r_pend_idx : 3'd0;
                        r_olast  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/lif_spiking_network_step.sv -----
// Leaky integrate-and-fire network engine, 32 neurons of 8 synapses, Q16.16.
// Commands enter on the s_axis channel: tuser carries the command code, tdata
// the fields. A tick returns one or more results on m_axis; other commands
// return none. Synapse and neuron writes complete in the engine's idle state.
// An injection sweeps all 256 synapse slots, reading then writing each slot.
// A tick visits each active neuron, stepping through its synapses one at a
// time, plus an injection sweep for every neuron that fires, so it runs
// shortest for an idle network and grows with every neuron that fires.
// A two-entry command queue lets the sender run ahead of the engine; results
// sit in an output register, and when the receiver stalls the engine waits
// before overwriting it. Reset clears potentials, refractory counts, currents,
// connection flags and active flags and loads the two registers with their
// defaults; the engine accepts commands from the first cycle after reset.
// Configuration writes on i_cfg_* take effect at once and are meant for idle.
// Depends on lsn_pkg, lsn_front and lsn_engine.
module lif_spiking_network_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [23:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // neuron, slot, source, link_valid, weight, threshold, rest_level,
    // leak_gain, decay, active, spike_count, zero fill
    input  logic [lsn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // output_index, zero fill
    output logic [7:0]                     m_axis_tdata,
    // fired
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    lsn_pkg::t_item w_item;
    logic           w_valid, w_pop;

    lsn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (w_valid),
        .o_item        (w_item),
        .i_pop         (w_pop)
    );

    lsn_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (w_valid),
        .i_item        (w_item),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
